// ===== rtl/svd_pkg.sv =====
// Shared types, register indexes and constants for the steam valve detector.
package svd_pkg;

    localparam int PRESS_W = 12;
    localparam int TEMP_W  = 12;
    localparam int DUTY_W  = 7;
    localparam int CFG_W   = 12;
    localparam int IDX_W   = 3;

    // Register indexes on the configuration port
    localparam logic [IDX_W-1:0] REG_STEAM_SETPOINT = 3'd0;
    localparam logic [IDX_W-1:0] REG_DROP_THRESHOLD = 3'd1;
    localparam logic [IDX_W-1:0] REG_RISE_THRESHOLD = 3'd2;
    localparam logic [IDX_W-1:0] REG_PEAK_CAP       = 3'd3;
    localparam logic [IDX_W-1:0] REG_OPEN_PUMP_DUTY = 3'd4;

    // Register reset values
    localparam logic [TEMP_W-1:0]  RST_STEAM_SETPOINT = 12'd2240;
    localparam logic [PRESS_W-1:0] RST_DROP_THRESHOLD = 12'd256;
    localparam logic [PRESS_W-1:0] RST_RISE_THRESHOLD = 12'd256;
    localparam logic [PRESS_W-1:0] RST_PEAK_CAP       = 12'd1536;
    localparam logic [DUTY_W-1:0]  RST_OPEN_PUMP_DUTY = 7'd5;

    localparam logic [DUTY_W-1:0] DUTY_MAX  = 7'd100;
    localparam logic [DUTY_W-1:0] DUTY_ZERO = 7'd0;

    // Phase codes
    localparam logic [1:0] PH_HEAT   = 2'd0;
    localparam logic [1:0] PH_CLOSED = 2'd1;
    localparam logic [1:0] PH_OPEN   = 2'd2;

    // Steam light codes
    localparam logic [1:0] LIGHT_OFF    = 2'd0;
    localparam logic [1:0] LIGHT_STEADY = 2'd1;
    localparam logic [1:0] LIGHT_BLINK  = 2'd2;

    typedef struct packed {
        logic [PRESS_W-1:0] pressure_sample;
        logic [TEMP_W-1:0]  temperature_sample;
    } sample_t;

    typedef struct packed {
        logic [1:0]        phase;
        logic              heater_on;
        logic [DUTY_W-1:0] pump_duty;
        logic [1:0]        light_mode;
    } result_t;

endpackage

// ===== rtl/steam_valve_detector_top.sv =====
// Steam valve detector: phase supervisor, peak/valley trackers and thermostat.
// Flow: an accepted word waits in the input stage; its result is loaded into the
// result register when that register is empty or drained. Throughput: one word
// per cycle unless result_ready stalls; the update is a single pass of compares.
// Reset: async active low; clears handshake state, trackers, phase (heating)
// and restores the configuration registers to their defaults.
module steam_valve_detector_top (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sample_valid,
    output logic                   sample_ready,
    input  svd_pkg::sample_t       sample,
    output logic                   result_valid,
    input  logic                   result_ready,
    output svd_pkg::result_t       result,
    input  logic                   cfg_we,
    input  logic [svd_pkg::IDX_W-1:0] cfg_index,
    input  logic [svd_pkg::CFG_W-1:0] cfg_data
);
    import svd_pkg::*;

    // Configuration registers
    logic [TEMP_W-1:0]  setpoint_reg;
    logic [PRESS_W-1:0] drop_thr_reg;
    logic [PRESS_W-1:0] rise_thr_reg;
    logic [PRESS_W-1:0] peak_cap_reg;
    logic [DUTY_W-1:0]  open_duty_reg;

    // Detector state
    logic [1:0]         phase_reg,  phase_next;
    logic [PRESS_W-1:0] peak_reg,   peak_next;
    logic [PRESS_W-1:0] valley_reg, valley_next;
    logic [DUTY_W-1:0]  pump_reg,   pump_next;

    // Input stage and result stage
    logic    stage_valid_reg;
    sample_t stage_reg;
    logic    out_valid_reg;
    result_t out_reg, out_next;

    logic out_load;

    // Advance the input stage into the result register when the result
    // register is empty or being drained this cycle. The input side takes a
    // new word whenever the stage is empty or moving on.
    assign out_load     = stage_valid_reg && (!out_valid_reg || result_ready);
    assign sample_ready = !stage_valid_reg || out_load;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Configuration writes; indexes past the last register are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg  <= RST_STEAM_SETPOINT;
            drop_thr_reg  <= RST_DROP_THRESHOLD;
            rise_thr_reg  <= RST_RISE_THRESHOLD;
            peak_cap_reg  <= RST_PEAK_CAP;
            open_duty_reg <= RST_OPEN_PUMP_DUTY;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_STEAM_SETPOINT: setpoint_reg  <= cfg_data[TEMP_W-1:0];
                REG_DROP_THRESHOLD: drop_thr_reg  <= cfg_data[PRESS_W-1:0];
                REG_RISE_THRESHOLD: rise_thr_reg  <= cfg_data[PRESS_W-1:0];
                REG_PEAK_CAP:       peak_cap_reg  <= cfg_data[PRESS_W-1:0];
                REG_OPEN_PUMP_DUTY: open_duty_reg <= cfg_data[DUTY_W-1:0];
                default:            ;
            endcase
        end
    end

    // One pass of the phase machine on the staged word.
    always_comb
    begin
        logic [PRESS_W-1:0] p;
        logic [TEMP_W-1:0]  t;
        logic [PRESS_W-1:0] pk;
        logic [PRESS_W-1:0] vl;
        logic [DUTY_W-1:0]  open_duty_sat;

        p  = stage_reg.pressure_sample;
        t  = stage_reg.temperature_sample;
        pk = peak_reg;
        vl = valley_reg;
        open_duty_sat = (open_duty_reg > DUTY_MAX) ? DUTY_MAX : open_duty_reg;

        phase_next  = phase_reg;
        peak_next   = peak_reg;
        valley_next = valley_reg;
        pump_next   = pump_reg;

        case (phase_reg)
            PH_CLOSED:
            begin
                // Track the peak below the cap, then look for a fall.
                if (p > pk && p < peak_cap_reg)
                begin
                    pk = p;
                end
                peak_next = pk;
                if (pk > p && (pk - p) > drop_thr_reg)
                begin
                    phase_next  = PH_OPEN;
                    pump_next   = open_duty_sat;
                    valley_next = p;
                end
            end
            PH_OPEN:
            begin
                // Track the valley, then look for a rise.
                if (p < vl)
                begin
                    vl = p;
                end
                valley_next = vl;
                if (p > vl && (p - vl) > rise_thr_reg)
                begin
                    phase_next = PH_CLOSED;
                    pump_next  = DUTY_ZERO;
                    peak_next  = p;
                end
            end
            default:
            begin
                // Heating (and the unused code): seed both trackers on the
                // first hot sample. A zero difference cannot fire the opening.
                phase_next = PH_HEAT;
                if (t > setpoint_reg)
                begin
                    phase_next  = PH_CLOSED;
                    peak_next   = p;
                    valley_next = p;
                end
            end
        endcase

        out_next.phase     = phase_next;
        out_next.pump_duty = pump_next;
        if (phase_next == PH_HEAT)
        begin
            out_next.heater_on  = 1'b1;
            out_next.light_mode = LIGHT_OFF;
        end
        else
        begin
            out_next.heater_on  = (t < setpoint_reg);
            out_next.light_mode = (phase_next == PH_OPEN) ? LIGHT_BLINK : LIGHT_STEADY;
        end
    end

    // Hold state and handshake registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            phase_reg       <= PH_HEAT;
            peak_reg        <= '0;
            valley_reg      <= '0;
            pump_reg        <= DUTY_ZERO;
        end
        else
        begin
            if (sample_ready)
            begin
                stage_valid_reg <= sample_valid;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                peak_reg      <= peak_next;
                valley_reg    <= valley_next;
                pump_reg      <= pump_next;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
        begin
            stage_reg <= sample;
        end
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

endmodule

// ===== rtl/svd_checker.sv =====
// Port-level checker for the steam valve detector and its bind.
module svd_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       result_valid,
    input logic                       result_ready,
    input svd_pkg::result_t           result
);
    import svd_pkg::*;

    // A stalled result word holds.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    // Light follows phase.
    a_light_phase: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            (result.phase == PH_HEAT   && result.light_mode == LIGHT_OFF) ||
            (result.phase == PH_CLOSED && result.light_mode == LIGHT_STEADY) ||
            (result.phase == PH_OPEN   && result.light_mode == LIGHT_BLINK))
        else $error("light mode does not match phase");

    // Heating forces the heater on and the pump off.
    a_heat_outputs: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.phase == PH_HEAT |->
            result.heater_on && result.pump_duty == DUTY_ZERO)
        else $error("heating phase with heater off or pump running");

    // Pump stopped with valve closed, and duty never above DUTY_MAX.
    a_pump_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            (result.phase != PH_CLOSED || result.pump_duty == DUTY_ZERO) &&
            result.pump_duty <= DUTY_MAX)
        else $error("pump duty out of range for phase");

endmodule

bind steam_valve_detector_top svd_checker u_svd_checker (.*);
